// ===== src/cbhf_pkg.sv =====
// shared types and constants for the crc-4 block header framer
package cbhf_pkg;

    localparam int BYTE_W      = 8;
    localparam int BLOCK_BYTES = 16;
    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int CRC_W       = 4;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);

    // x^4+x+1 with the top term; the low nibble is the feedback mask
    localparam logic [CRC_W:0] CRC_POLY = 5'h13;

    // framer sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_HDR,
        ST_RD,
        ST_DATA
    } t_state;

    // control from the sequencer to the serial crc unit
    typedef struct packed {
        logic load;
        logic clear;
    } t_crc_ctl;

endpackage

// ===== src/cbhf_stream_if.sv =====
// valid/ready channels for message bytes in and framed bytes out
interface cbhf_in_if;
    logic                           valid;
    logic                           ready;
    logic [cbhf_pkg::BYTE_W-1:0]    data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cbhf_out_if;
    logic                           valid;
    logic                           ready;
    logic [cbhf_pkg::BYTE_W-1:0]    out_byte;
    logic                           is_header;
    logic                           end_of_block;

    modport source (output valid, output out_byte, output is_header, output end_of_block,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header, input end_of_block,
                    output ready);
endinterface

// ===== src/cbhf_crc_serial.sv =====
// bit-serial crc-4 unit, one message bit per cycle, msb first
module cbhf_crc_serial (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbhf_pkg::t_crc_ctl            i_ctl,
    input  logic [cbhf_pkg::BYTE_W-1:0]   i_data,
    output logic [cbhf_pkg::CRC_W-1:0]    o_crc,
    output logic                          o_busy
);

    logic [cbhf_pkg::CRC_W-1:0]     r_crc;
    logic [cbhf_pkg::CRC_W-1:0]     n_crc;
    logic [cbhf_pkg::BYTE_W-1:0]    r_shift;
    logic [cbhf_pkg::BIT_CNT_W-1:0] r_bit;
    logic                           r_busy;
    logic                           w_fb;

    // one lfsr step on the current top bit of the byte
    always_comb begin
        w_fb  = r_crc[cbhf_pkg::CRC_W-1] ^ r_shift[cbhf_pkg::BYTE_W-1];
        n_crc = {r_crc[cbhf_pkg::CRC_W-2:0], 1'b0}
              ^ (w_fb ? cbhf_pkg::CRC_POLY[cbhf_pkg::CRC_W-1:0] : '0);
    end

    // crc register and bit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_ctl.clear) begin
            r_crc  <= '0;
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_bit  <= '0;
        end else if (r_busy) begin
            r_crc <= n_crc;
            r_bit <= r_bit + 1'b1;
            if (r_bit == cbhf_pkg::BIT_CNT_W'(cbhf_pkg::BYTE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // byte shifter, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= i_data;
        end else if (r_busy) begin
            r_shift <= {r_shift[cbhf_pkg::BYTE_W-2:0], 1'b0};
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

    // a load never lands on a byte still being shifted
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !r_busy)
        else $error("crc load while busy");

    // a byte takes exactly eight steps, after which busy reads low
    a_eight_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load && !i_ctl.clear) |-> ##9 (!r_busy || i_ctl.clear || $past(i_ctl.clear)))
        else $error("crc byte did not finish in eight cycles");

    // crc only moves while busy or on clear
    a_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_ctl.clear) |=> $stable(r_crc))
        else $error("crc changed while idle");

endmodule

// ===== src/crc4_block_header_framer_unit.sv =====
// top level of the crc-4 block header framer
//
//  port      dir  handshake        payload
//  i_in      in   valid / ready    data_byte[7:0], last_byte
//  o_out     out  valid / ready    out_byte[7:0], is_header, end_of_block
//
//  each input request is accepted in the idle state, then takes 8 bit-serial crc steps,
//  and leaves the crc state once the crc unit goes idle
//  a block of n bytes then emits n+1 output bytes; the header, then for each data byte
//  a store read state and an output state, plus any stalls from o_out.ready
//  input is not taken while a block is being emitted
//  reset (i_rst_n low, synchronous) empties the block and clears the crc
module crc4_block_header_framer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbhf_in_if.sink           i_in,
    cbhf_out_if.source        o_out
);

    cbhf_pkg::t_state               r_state;
    cbhf_pkg::t_state               n_state;
    logic [cbhf_pkg::CNT_W-1:0]     r_count;
    logic [cbhf_pkg::CNT_W-1:0]     n_count;
    logic [cbhf_pkg::CNT_W-1:0]     r_idx;
    logic [cbhf_pkg::CNT_W-1:0]     n_idx;
    logic [cbhf_pkg::CNT_W-1:0]     w_cnt_m1;
    logic                           r_last;
    logic [cbhf_pkg::BYTE_W-1:0]    r_mem [cbhf_pkg::STORE_DEPTH];
    logic [cbhf_pkg::BYTE_W-1:0]    r_rd_data;
    cbhf_pkg::t_crc_ctl             w_crc_ctl;
    logic [cbhf_pkg::CRC_W-1:0]     w_crc;
    logic                           w_crc_busy;
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_full;
    logic                           w_blk_end;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_full    = (r_count == cbhf_pkg::CNT_W'(cbhf_pkg::BLOCK_BYTES));
    assign w_cnt_m1  = r_count - cbhf_pkg::CNT_W'(1);
    assign w_blk_end = (r_idx == w_cnt_m1);

    // serial crc over each accepted byte
    cbhf_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_data  (i_in.data_byte),
        .o_crc   (w_crc),
        .o_busy  (w_crc_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbhf_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = cbhf_pkg::ST_CRC;
                end
            end
            cbhf_pkg::ST_CRC: begin
                if (!w_crc_busy) begin
                    n_state = (r_last || w_full) ? cbhf_pkg::ST_HDR : cbhf_pkg::ST_IDLE;
                end
            end
            cbhf_pkg::ST_HDR: begin
                if (w_out_acc) begin
                    n_state = cbhf_pkg::ST_RD;
                end
            end
            cbhf_pkg::ST_RD: begin
                n_state = cbhf_pkg::ST_DATA;
            end
            cbhf_pkg::ST_DATA: begin
                if (w_out_acc) begin
                    n_state = w_blk_end ? cbhf_pkg::ST_IDLE : cbhf_pkg::ST_RD;
                end
            end
            default: begin
                n_state = cbhf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and counter updates
    always_comb begin
        i_in.ready         = 1'b0;
        o_out.valid        = 1'b0;
        o_out.is_header    = 1'b0;
        o_out.end_of_block = 1'b0;
        o_out.out_byte     = r_rd_data;
        w_crc_ctl          = '0;
        n_count            = r_count;
        n_idx              = r_idx;
        unique case (r_state)
            cbhf_pkg::ST_IDLE: begin
                i_in.ready     = 1'b1;
                w_crc_ctl.load = i_in.valid;
                if (i_in.valid) begin
                    n_count = r_count + cbhf_pkg::CNT_W'(1);
                end
            end
            cbhf_pkg::ST_CRC: begin
                n_idx = '0;
            end
            cbhf_pkg::ST_HDR: begin
                o_out.valid     = 1'b1;
                o_out.is_header = 1'b1;
                o_out.out_byte  = {w_crc, w_cnt_m1[cbhf_pkg::IDX_W-1:0]};
            end
            cbhf_pkg::ST_RD: begin
            end
            cbhf_pkg::ST_DATA: begin
                o_out.valid        = 1'b1;
                o_out.end_of_block = w_blk_end;
                if (w_out_acc) begin
                    n_idx = r_idx + cbhf_pkg::CNT_W'(1);
                    if (w_blk_end) begin
                        n_count         = '0;
                        w_crc_ctl.clear = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbhf_pkg::ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // last flag captured with the request
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last <= i_in.last_byte;
        end
    end

    // block store, written on accept, read with registered data
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_count[cbhf_pkg::IDX_W-1:0]] <= i_in.data_byte;
        end
        r_rd_data <= r_mem[r_idx[cbhf_pkg::IDX_W-1:0]];
    end

    // input and output never handshake in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while emitting");

    // header is followed by the store read state, then the first data byte
    a_hdr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.is_header) |=> !o_out.valid ##1 (o_out.valid && !o_out.is_header))
        else $error("data byte did not follow header");

    // fill count never passes the block size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cbhf_pkg::CNT_W'(cbhf_pkg::BLOCK_BYTES))
        else $error("fill count overflow");

    // the block ends on its last data byte with the count cleared
    a_block_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.end_of_block) |=> (r_count == '0 && i_in.ready))
        else $error("block not closed after last byte");

endmodule
